// ===== rtl/core/nrmc_pkg.sv =====
package nrmc_pkg;

    // Defaults for the top-level parameters
    localparam int MINUTE_FRACTION_DIGITS_DEF = 5;
    localparam int MAX_SENTENCE_BYTES_DEF     = 80;

    // Depth of the record queue between parser and converter
    localparam int QUEUE_DEPTH = 2;

    // Fixed widths of the raw sentence accumulators
    localparam int TIME_W = 20;
    localparam int LAT_W  = 14;
    localparam int LON_W  = 17;
    localparam int HEM_W  = 2;

    localparam int OFFSET_W     = 5;
    localparam logic [OFFSET_W-1:0] UTC_OFFSET_RESET = 5'd8;

    localparam logic [TIME_W-1:0] TIME_CAP      = 20'd999999;
    localparam logic [LAT_W-1:0]  LAT_WHOLE_CAP = 14'd9999;
    localparam logic [LON_W-1:0]  LON_WHOLE_CAP = 17'd99999;

    // Result widths
    localparam int HHMMSS_W = 18;
    localparam int LAT_E7_W = 30;
    localparam int LON_E7_W = 31;

    // ASCII codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic int pow10(input int n);
        int r;
        r = 1;
        case (n)
            0: r = 1;
            1: r = 10;
            2: r = 100;
            3: r = 1000;
            4: r = 10000;
            5: r = 100000;
            6: r = 1000000;
            7: r = 10000000;
            default: r = 1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/nrmc_fifo.sv =====
module nrmc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output nrmc_pkg::q_stat_t  stat
);
    import nrmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/nrmc_front.sv =====
module nrmc_front #(
    parameter int MINUTE_FRACTION_DIGITS = 5,
    parameter int MAX_SENTENCE_BYTES     = 80
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  logic [7:0]                                   s_rx_byte,
    input  nrmc_pkg::q_stat_t                            q_stat,
    output logic                                         rec_push,
    output logic                                         rec_fix_ok,
    output logic [nrmc_pkg::TIME_W-1:0]                  rec_time,
    output logic [nrmc_pkg::LAT_W-1:0]                   rec_lat_whole,
    output logic [$clog2(10**MINUTE_FRACTION_DIGITS)-1:0] rec_lat_frac,
    output logic [nrmc_pkg::LON_W-1:0]                   rec_lon_whole,
    output logic [$clog2(10**MINUTE_FRACTION_DIGITS)-1:0] rec_lon_frac,
    output logic [nrmc_pkg::HEM_W-1:0]                   rec_hem
);
    import nrmc_pkg::*;

    localparam int FD     = MINUTE_FRACTION_DIGITS;
    localparam int FRAC_W = $clog2(10**FD);
    localparam int FD_W   = $clog2(FD + 1);
    localparam int SB_W   = $clog2(MAX_SENTENCE_BYTES + 1);

    // Header position: hunting, header characters matched, in body
    localparam logic [2:0] HP_HUNT = 3'd0;
    localparam logic [2:0] HP_ONE  = 3'd1;
    localparam logic [2:0] HP_BODY = 3'd6;

    localparam logic [2:0] FLD_TIME   = 3'd1;
    localparam logic [2:0] FLD_STATUS = 3'd2;
    localparam logic [2:0] FLD_LAT    = 3'd3;
    localparam logic [2:0] FLD_NS     = 3'd4;
    localparam logic [2:0] FLD_LON    = 3'd5;
    localparam logic [2:0] FLD_EW     = 3'd6;

    logic [2:0]        hp_reg, hp_next;
    logic [2:0]        fn_reg, fn_next;
    logic [SB_W-1:0]   sb_reg, sb_next;
    logic              ap_reg, ap_next;
    logic [FD_W-1:0]   fd_reg, fd_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic [LAT_W-1:0]  lat_w_reg, lat_w_next;
    logic [FRAC_W-1:0] lat_f_reg, lat_f_next;
    logic [LON_W-1:0]  lon_w_reg, lon_w_next;
    logic [FRAC_W-1:0] lon_f_reg, lon_f_next;
    logic [HEM_W-1:0]  hem_reg, hem_next;
    logic              st_reg, st_next;

    logic              accept;
    logic              is_digit;
    logic [3:0]        digit_val;
    logic [23:0]       time_mac;
    logic [16:0]       lat_mac;
    logic [19:0]       lon_mac;
    logic [FRAC_W+3:0] lat_fmac, lon_fmac;
    logic [FRAC_W-1:0] pad_src;
    logic [FRAC_W:0]   pad_mul;
    logic [2*FRAC_W:0] pad_prod;
    logic              frac_room;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] c;
        c = CH_DOLLAR;
        case (pos)
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_R;
            3'd4:    c = CH_M;
            3'd5:    c = CH_C;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

    assign s_ready   = !q_stat.full;
    assign accept    = s_valid && s_ready;
    assign is_digit  = (s_rx_byte >= CH_ZERO) && (s_rx_byte <= CH_NINE);
    assign digit_val = is_digit ? s_rx_byte[3:0] : 4'd0;
    assign frac_room = (fd_reg < FD_W'(FD));

    assign time_mac = 24'(time_reg) * 24'd10 + 24'(digit_val);
    assign lat_mac  = 17'(lat_w_reg) * 17'd10 + 17'(digit_val);
    assign lon_mac  = 20'(lon_w_reg) * 20'd10 + 20'(digit_val);
    assign lat_fmac = (FRAC_W+4)'(lat_f_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit_val);
    assign lon_fmac = (FRAC_W+4)'(lon_f_reg) * (FRAC_W+4)'(10) + (FRAC_W+4)'(digit_val);

    // Pad the fraction to full length when its field closes
    assign pad_src  = (fn_reg == FLD_LAT) ? lat_f_reg : lon_f_reg;
    assign pad_mul  = (FRAC_W+1)'(pow10(FD - int'(fd_reg)));
    assign pad_prod = (2*FRAC_W+1)'(pad_src) * (2*FRAC_W+1)'(pad_mul);

    assign rec_time      = time_reg;
    assign rec_lat_whole = lat_w_reg;
    assign rec_lat_frac  = lat_f_reg;
    assign rec_lon_whole = lon_w_reg;
    assign rec_lon_frac  = lon_f_reg;
    assign rec_hem       = hem_reg;

    always_comb begin
        hp_next    = hp_reg;
        fn_next    = fn_reg;
        sb_next    = sb_reg;
        ap_next    = ap_reg;
        fd_next    = fd_reg;
        time_next  = time_reg;
        lat_w_next = lat_w_reg;
        lat_f_next = lat_f_reg;
        lon_w_next = lon_w_reg;
        lon_f_next = lon_f_reg;
        hem_next   = hem_reg;
        st_next    = st_reg;
        rec_push   = 1'b0;
        rec_fix_ok = 1'b0;

        if (accept) begin
            if (s_rx_byte == CH_DOLLAR) begin
                // Start over on any dollar
                hp_next    = HP_ONE;
                fn_next    = '0;
                sb_next    = SB_W'(1);
                ap_next    = 1'b0;
                fd_next    = '0;
                time_next  = '0;
                lat_w_next = '0;
                lat_f_next = '0;
                lon_w_next = '0;
                lon_f_next = '0;
                hem_next   = '0;
                st_next    = 1'b0;
            end else if (hp_reg != HP_HUNT) begin
                if (sb_reg >= SB_W'(MAX_SENTENCE_BYTES)) begin
                    hp_next = HP_HUNT;
                end else begin
                    sb_next = sb_reg + 1'b1;
                    if (hp_reg < HP_BODY) begin
                        hp_next = (s_rx_byte == hdr_char(hp_reg)) ? hp_reg + 1'b1 : HP_HUNT;
                    end else if (s_rx_byte == CH_STAR || s_rx_byte == CH_CR ||
                                 s_rx_byte == CH_LF) begin
                        hp_next = HP_HUNT;
                    end else if (s_rx_byte == CH_COMMA) begin
                        if (fn_reg == FLD_STATUS && !st_reg) begin
                            rec_push = 1'b1;
                            hp_next  = HP_HUNT;
                        end else if (fn_reg == FLD_EW) begin
                            rec_push   = 1'b1;
                            rec_fix_ok = 1'b1;
                            hp_next    = HP_HUNT;
                        end else begin
                            if (fn_reg == FLD_LAT) begin
                                lat_f_next = FRAC_W'(pad_prod);
                            end
                            if (fn_reg == FLD_LON) begin
                                lon_f_next = FRAC_W'(pad_prod);
                            end
                            fn_next = fn_reg + 1'b1;
                            ap_next = 1'b0;
                            fd_next = '0;
                        end
                    end else begin
                        case (fn_reg)
                            FLD_TIME: begin
                                if (s_rx_byte == CH_POINT) begin
                                    ap_next = 1'b1;
                                end else if (is_digit && !ap_reg) begin
                                    time_next = (time_mac > 24'(TIME_CAP)) ?
                                                TIME_CAP : TIME_W'(time_mac);
                                end
                            end
                            FLD_STATUS: begin
                                // Only the first character counts
                                if (!ap_reg) begin
                                    st_next = (s_rx_byte == CH_A);
                                    ap_next = 1'b1;
                                end
                            end
                            FLD_LAT: begin
                                if (s_rx_byte == CH_POINT) begin
                                    ap_next = 1'b1;
                                end else if (is_digit) begin
                                    if (!ap_reg) begin
                                        lat_w_next = (lat_mac > 17'(LAT_WHOLE_CAP)) ?
                                                     LAT_WHOLE_CAP : LAT_W'(lat_mac);
                                    end else if (frac_room) begin
                                        lat_f_next = FRAC_W'(lat_fmac);
                                        fd_next    = fd_reg + 1'b1;
                                    end
                                end
                            end
                            FLD_NS: begin
                                hem_next[0] = (s_rx_byte == CH_S);
                            end
                            FLD_LON: begin
                                if (s_rx_byte == CH_POINT) begin
                                    ap_next = 1'b1;
                                end else if (is_digit) begin
                                    if (!ap_reg) begin
                                        lon_w_next = (lon_mac > 20'(LON_WHOLE_CAP)) ?
                                                     LON_WHOLE_CAP : LON_W'(lon_mac);
                                    end else if (frac_room) begin
                                        lon_f_next = FRAC_W'(lon_fmac);
                                        fd_next    = fd_reg + 1'b1;
                                    end
                                end
                            end
                            FLD_EW: begin
                                hem_next[1] = (s_rx_byte == CH_W);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hp_reg <= HP_HUNT;
            fn_reg <= '0;
            sb_reg <= '0;
            ap_reg <= 1'b0;
            fd_reg <= '0;
            st_reg <= 1'b0;
        end else begin
            hp_reg <= hp_next;
            fn_reg <= fn_next;
            sb_reg <= sb_next;
            ap_reg <= ap_next;
            fd_reg <= fd_next;
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        time_reg  <= time_next;
        lat_w_reg <= lat_w_next;
        lat_f_reg <= lat_f_next;
        lon_w_reg <= lon_w_next;
        lon_f_reg <= lon_f_next;
        hem_reg   <= hem_next;
    end

endmodule

// ===== rtl/core/nrmc_back.sv =====
module nrmc_back #(
    parameter int MINUTE_FRACTION_DIGITS = 5
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  nrmc_pkg::q_stat_t                            q_stat,
    output logic                                         q_pop,
    input  logic                                         rec_fix_ok,
    input  logic [nrmc_pkg::TIME_W-1:0]                  rec_time,
    input  logic [nrmc_pkg::LAT_W-1:0]                   rec_lat_whole,
    input  logic [$clog2(10**MINUTE_FRACTION_DIGITS)-1:0] rec_lat_frac,
    input  logic [nrmc_pkg::LON_W-1:0]                   rec_lon_whole,
    input  logic [$clog2(10**MINUTE_FRACTION_DIGITS)-1:0] rec_lon_frac,
    input  logic [nrmc_pkg::HEM_W-1:0]                   rec_hem,
    input  logic [nrmc_pkg::OFFSET_W-1:0]                utc_offset,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic [nrmc_pkg::HHMMSS_W-1:0]                m_local_time_hhmmss,
    output logic                                         m_fix_valid,
    output logic [nrmc_pkg::LAT_E7_W-1:0]                m_latitude_e7,
    output logic                                         m_lat_south,
    output logic [nrmc_pkg::LON_E7_W-1:0]                m_longitude_e7,
    output logic                                         m_lon_west
);
    import nrmc_pkg::*;

    localparam int FD      = MINUTE_FRACTION_DIGITS;
    localparam int FRAC_W  = $clog2(10**FD);
    localparam int MINS_W  = $clog2(100 * (10**FD));
    localparam int SCALE   = 10**(7 - FD);
    localparam int SCALE_W = $clog2(SCALE + 1);
    localparam int SC_W    = 30;             // minutes scaled to 1e-7 stay below 1e9
    localparam int HH_W    = 7;
    localparam int MIN_W   = 7;
    localparam int LATD_W  = 7;
    localparam int LOND_W  = 10;
    localparam int REST_W  = 14;
    localparam int LATP_W  = 30;             // up to 99 degrees times 1e7
    localparam int LONP_W  = 34;             // up to 999 degrees times 1e7
    localparam int STAGES  = 6;

    // Reciprocals for division by a constant; each quotient is low by at most one
    localparam int R10K   = (1 << TIME_W) / 10000;
    localparam int R10K_W = $clog2(R10K + 1);
    localparam int R100A  = (1 << LAT_W) / 100;
    localparam int R100A_W = $clog2(R100A + 1);
    localparam int R100B  = (1 << LON_W) / 100;
    localparam int R100B_W = $clog2(R100B + 1);
    localparam int R60    = (1 << SC_W) / 60;
    localparam int R60_W  = $clog2(R60 + 1);

    localparam logic [LAT_E7_W-1:0] LAT_CAP = 30'd900000000;
    localparam logic [LON_E7_W-1:0] LON_CAP = 31'd1800000000;

    logic                 en;
    logic [STAGES-1:0]    sv_reg;
    logic                 m_valid_reg;

    // Stage 1: reciprocal products
    logic                 s1_ok_reg;
    logic [HEM_W-1:0]     s1_hem_reg;
    logic [TIME_W-1:0]    s1_t_reg;
    logic [LAT_W-1:0]     s1_latw_reg;
    logic [LON_W-1:0]     s1_lonw_reg;
    logic [FRAC_W-1:0]    s1_latf_reg, s1_lonf_reg;
    logic [HH_W-1:0]      s1_hh_reg;
    logic [LATD_W-1:0]    s1_latd_reg;
    logic [LOND_W-1:0]    s1_lond_reg;
    logic [TIME_W+R10K_W-1:0]  prod_t;
    logic [LAT_W+R100A_W-1:0]  prod_lat;
    logic [LON_W+R100B_W-1:0]  prod_lon;

    // Stage 2: quotient correction
    logic                 s2_ok_reg;
    logic [HEM_W-1:0]     s2_hem_reg;
    logic [FRAC_W-1:0]    s2_latf_reg, s2_lonf_reg;
    logic [HH_W-1:0]      s2_hh_reg;
    logic [REST_W-1:0]    s2_rest_reg;
    logic [LATD_W-1:0]    s2_latd_reg;
    logic [LOND_W-1:0]    s2_lond_reg;
    logic [MIN_W-1:0]     s2_latm_reg, s2_lonm_reg;
    logic [TIME_W-1:0]    rem_t;
    logic [LAT_W-1:0]     rem_lat;
    logic [LON_W-1:0]     rem_lon;

    // Stage 3: minutes assembled, degrees scaled, hour shifted
    logic                 s3_ok_reg;
    logic [HEM_W-1:0]     s3_hem_reg;
    logic [4:0]           s3_lh_reg;
    logic [REST_W-1:0]    s3_rest_reg;
    logic [MINS_W-1:0]    s3_latmin_reg, s3_lonmin_reg;
    logic [LATP_W-1:0]    s3_latp_reg;
    logic [LONP_W-1:0]    s3_lonp_reg;

    // Stage 4: minutes to 1e-7 units, time packed
    logic                 s4_ok_reg;
    logic [HEM_W-1:0]     s4_hem_reg;
    logic [HHMMSS_W-1:0]  s4_time_reg;
    logic [SC_W-1:0]      s4_latsc_reg, s4_lonsc_reg;
    logic [LATP_W-1:0]    s4_latp_reg;
    logic [LONP_W-1:0]    s4_lonp_reg;
    logic [MINS_W+SCALE_W-1:0] sc_lat, sc_lon;

    // Stage 5: divide by 60, estimate
    logic                 s5_ok_reg;
    logic [HEM_W-1:0]     s5_hem_reg;
    logic [HHMMSS_W-1:0]  s5_time_reg;
    logic [SC_W-1:0]      s5_latsc_reg, s5_lonsc_reg;
    logic [R60_W-1:0]     s5_latq_reg, s5_lonq_reg;
    logic [LATP_W-1:0]    s5_latp_reg;
    logic [LONP_W-1:0]    s5_lonp_reg;
    logic [SC_W+R60_W-1:0] p60_lat, p60_lon;

    // Stage 6: divide by 60, correction
    logic                 s6_ok_reg;
    logic [HEM_W-1:0]     s6_hem_reg;
    logic [HHMMSS_W-1:0]  s6_time_reg;
    logic [R60_W-1:0]     s6_latq_reg, s6_lonq_reg;
    logic [LATP_W-1:0]    s6_latp_reg;
    logic [LONP_W-1:0]    s6_lonp_reg;
    logic [SC_W-1:0]      r60_lat, r60_lon;

    // Output register
    logic [HHMMSS_W-1:0]  out_time_reg;
    logic                 out_ok_reg;
    logic [LAT_E7_W-1:0]  out_lat_reg;
    logic [LON_E7_W-1:0]  out_lon_reg;
    logic [HEM_W-1:0]     out_hem_reg;
    logic [LATP_W:0]      sum_lat;
    logic [LONP_W:0]      sum_lon;

    function automatic logic [4:0] mod24(input logic [7:0] s);
        logic [7:0] v;
        v = s;
        for (int i = 0; i < 6; i++) begin
            if (v >= 8'd24) begin
                v = v - 8'd24;
            end
        end
        return v[4:0];
    endfunction

    // Advance the whole pipe unless the result waits
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_stat.empty;

    assign prod_t   = (TIME_W+R10K_W)'(rec_time) * (TIME_W+R10K_W)'(R10K);
    assign prod_lat = (LAT_W+R100A_W)'(rec_lat_whole) * (LAT_W+R100A_W)'(R100A);
    assign prod_lon = (LON_W+R100B_W)'(rec_lon_whole) * (LON_W+R100B_W)'(R100B);

    assign rem_t   = s1_t_reg - TIME_W'(s1_hh_reg) * TIME_W'(10000);
    assign rem_lat = s1_latw_reg - LAT_W'(s1_latd_reg) * LAT_W'(100);
    assign rem_lon = s1_lonw_reg - LON_W'(s1_lond_reg) * LON_W'(100);

    assign sc_lon = (MINS_W+SCALE_W)'(s3_lonmin_reg) * (MINS_W+SCALE_W)'(SCALE);
    assign sc_lat = (MINS_W+SCALE_W)'(s3_latmin_reg) * (MINS_W+SCALE_W)'(SCALE);

    assign p60_lat = (SC_W+R60_W)'(s4_latsc_reg) * (SC_W+R60_W)'(R60);
    assign p60_lon = (SC_W+R60_W)'(s4_lonsc_reg) * (SC_W+R60_W)'(R60);

    assign r60_lat = s5_latsc_reg - SC_W'(s5_latq_reg) * SC_W'(60);
    assign r60_lon = s5_lonsc_reg - SC_W'(s5_lonq_reg) * SC_W'(60);

    assign sum_lat = (LATP_W+1)'(s6_latp_reg) + (LATP_W+1)'(s6_latq_reg);
    assign sum_lon = (LONP_W+1)'(s6_lonp_reg) + (LONP_W+1)'(s6_lonq_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            sv_reg      <= {sv_reg[STAGES-2:0], q_pop};
            m_valid_reg <= sv_reg[STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ok_reg   <= rec_fix_ok;
            s1_hem_reg  <= rec_hem;
            s1_t_reg    <= rec_time;
            s1_latw_reg <= rec_lat_whole;
            s1_lonw_reg <= rec_lon_whole;
            s1_latf_reg <= rec_lat_frac;
            s1_lonf_reg <= rec_lon_frac;
            s1_hh_reg   <= prod_t[TIME_W +: HH_W];
            s1_latd_reg <= prod_lat[LAT_W +: LATD_W];
            s1_lond_reg <= prod_lon[LON_W +: LOND_W];

            s2_ok_reg   <= s1_ok_reg;
            s2_hem_reg  <= s1_hem_reg;
            s2_latf_reg <= s1_latf_reg;
            s2_lonf_reg <= s1_lonf_reg;
            if (rem_t >= TIME_W'(10000)) begin
                s2_hh_reg   <= s1_hh_reg + 1'b1;
                s2_rest_reg <= REST_W'(rem_t - TIME_W'(10000));
            end else begin
                s2_hh_reg   <= s1_hh_reg;
                s2_rest_reg <= REST_W'(rem_t);
            end
            if (rem_lat >= LAT_W'(100)) begin
                s2_latd_reg <= s1_latd_reg + 1'b1;
                s2_latm_reg <= MIN_W'(rem_lat - LAT_W'(100));
            end else begin
                s2_latd_reg <= s1_latd_reg;
                s2_latm_reg <= MIN_W'(rem_lat);
            end
            if (rem_lon >= LON_W'(100)) begin
                s2_lond_reg <= s1_lond_reg + 1'b1;
                s2_lonm_reg <= MIN_W'(rem_lon - LON_W'(100));
            end else begin
                s2_lond_reg <= s1_lond_reg;
                s2_lonm_reg <= MIN_W'(rem_lon);
            end

            s3_ok_reg     <= s2_ok_reg;
            s3_hem_reg    <= s2_hem_reg;
            s3_lh_reg     <= mod24(8'(s2_hh_reg) + 8'(utc_offset));
            s3_rest_reg   <= s2_rest_reg;
            s3_latmin_reg <= MINS_W'(s2_latm_reg) * MINS_W'(10**FD) + MINS_W'(s2_latf_reg);
            s3_lonmin_reg <= MINS_W'(s2_lonm_reg) * MINS_W'(10**FD) + MINS_W'(s2_lonf_reg);
            s3_latp_reg   <= LATP_W'(s2_latd_reg) * LATP_W'(10000000);
            s3_lonp_reg   <= LONP_W'(s2_lond_reg) * LONP_W'(10000000);

            s4_ok_reg    <= s3_ok_reg;
            s4_hem_reg   <= s3_hem_reg;
            s4_time_reg  <= HHMMSS_W'(s3_lh_reg) * HHMMSS_W'(10000) + HHMMSS_W'(s3_rest_reg);
            s4_latsc_reg <= SC_W'(sc_lat);
            s4_lonsc_reg <= SC_W'(sc_lon);
            s4_latp_reg  <= s3_latp_reg;
            s4_lonp_reg  <= s3_lonp_reg;

            s5_ok_reg    <= s4_ok_reg;
            s5_hem_reg   <= s4_hem_reg;
            s5_time_reg  <= s4_time_reg;
            s5_latsc_reg <= s4_latsc_reg;
            s5_lonsc_reg <= s4_lonsc_reg;
            s5_latq_reg  <= p60_lat[SC_W +: R60_W];
            s5_lonq_reg  <= p60_lon[SC_W +: R60_W];
            s5_latp_reg  <= s4_latp_reg;
            s5_lonp_reg  <= s4_lonp_reg;

            s6_ok_reg   <= s5_ok_reg;
            s6_hem_reg  <= s5_hem_reg;
            s6_time_reg <= s5_time_reg;
            s6_latq_reg <= (r60_lat >= SC_W'(60)) ? s5_latq_reg + 1'b1 : s5_latq_reg;
            s6_lonq_reg <= (r60_lon >= SC_W'(60)) ? s5_lonq_reg + 1'b1 : s5_lonq_reg;
            s6_latp_reg <= s5_latp_reg;
            s6_lonp_reg <= s5_lonp_reg;

            // Zero the position on an invalid fix, clamp to the legal range
            out_time_reg <= s6_time_reg;
            out_ok_reg   <= s6_ok_reg;
            out_hem_reg  <= s6_ok_reg ? s6_hem_reg : '0;
            if (!s6_ok_reg) begin
                out_lat_reg <= '0;
            end else if (sum_lat > (LATP_W+1)'(LAT_CAP)) begin
                out_lat_reg <= LAT_CAP;
            end else begin
                out_lat_reg <= LAT_E7_W'(sum_lat);
            end
            if (!s6_ok_reg) begin
                out_lon_reg <= '0;
            end else if (sum_lon > (LONP_W+1)'(LON_CAP)) begin
                out_lon_reg <= LON_CAP;
            end else begin
                out_lon_reg <= LON_E7_W'(sum_lon);
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_local_time_hhmmss = out_time_reg;
    assign m_fix_valid         = out_ok_reg;
    assign m_latitude_e7       = out_lat_reg;
    assign m_lat_south         = out_hem_reg[0];
    assign m_longitude_e7      = out_lon_reg;
    assign m_lon_west          = out_hem_reg[1];

endmodule

// ===== rtl/core/nmea_rmc_sentence_parser.sv =====
// RMC sentence parser for a GPS serial byte stream.
// Input channel s_*: one received character per beat on s_rx_byte. The block
// hunts for "$GPRMC", splits the fields at commas and collects time, status,
// latitude and longitude. Up to one byte is taken per cycle.
// Result channel m_*: one beat per sentence, at the comma that closes the
// E/W field, or at the comma that closes the status field on an invalid fix
// (then position and hemisphere bits are zero). Time is hhmmss after adding
// the hour offset written through cfg_wr_en/cfg_wr_data, mod 24.
// Path: a record pushed at the closing comma leaves the queue into the 6-stage
// conversion pipe (constant divides by reciprocal multiply and correction),
// then passes the output register. Throughput: one byte per cycle while
// s_ready is high; results can follow back to back.
// A 2-entry record queue parts the byte parser from the conversion pipe. When
// m_ready is low the pipe holds, the queue fills, and s_ready drops only while
// the queue is full.
// Reset: aresetn low at a clock edge clears the parser to hunting, empties the
// queue and the pipe, and sets the hour offset to 8.
module nmea_rmc_sentence_parser #(
    parameter int MINUTE_FRACTION_DIGITS = nrmc_pkg::MINUTE_FRACTION_DIGITS_DEF,
    parameter int MAX_SENTENCE_BYTES     = nrmc_pkg::MAX_SENTENCE_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_rx_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [nrmc_pkg::HHMMSS_W-1:0]  m_local_time_hhmmss,
    output logic                           m_fix_valid,
    output logic [nrmc_pkg::LAT_E7_W-1:0]  m_latitude_e7,
    output logic                           m_lat_south,
    output logic [nrmc_pkg::LON_E7_W-1:0]  m_longitude_e7,
    output logic                           m_lon_west,
    input  logic                           cfg_wr_en,
    input  logic [nrmc_pkg::OFFSET_W-1:0]  cfg_wr_data
);
    import nrmc_pkg::*;

    localparam int FRAC_W = $clog2(10**MINUTE_FRACTION_DIGITS);
    localparam int REC_W  = 1 + HEM_W + 2 * FRAC_W + LON_W + LAT_W + TIME_W;

    logic [OFFSET_W-1:0] utc_offset_reg;

    q_stat_t             q_stat;
    logic                rec_push, q_pop;
    logic                fr_ok, bk_ok;
    logic [TIME_W-1:0]   fr_time, bk_time;
    logic [LAT_W-1:0]    fr_latw, bk_latw;
    logic [FRAC_W-1:0]   fr_latf, bk_latf;
    logic [LON_W-1:0]    fr_lonw, bk_lonw;
    logic [FRAC_W-1:0]   fr_lonf, bk_lonf;
    logic [HEM_W-1:0]    fr_hem, bk_hem;
    logic [REC_W-1:0]    q_wdata, q_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_offset_reg <= UTC_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            utc_offset_reg <= cfg_wr_data;
        end
    end

    nrmc_front #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS),
        .MAX_SENTENCE_BYTES     (MAX_SENTENCE_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .q_stat        (q_stat),
        .rec_push      (rec_push),
        .rec_fix_ok    (fr_ok),
        .rec_time      (fr_time),
        .rec_lat_whole (fr_latw),
        .rec_lat_frac  (fr_latf),
        .rec_lon_whole (fr_lonw),
        .rec_lon_frac  (fr_lonf),
        .rec_hem       (fr_hem)
    );

    assign q_wdata = {fr_ok, fr_hem, fr_lonf, fr_lonw, fr_latf, fr_latw, fr_time};
    assign {bk_ok, bk_hem, bk_lonf, bk_lonw, bk_latf, bk_latw, bk_time} = q_rdata;

    nrmc_fifo #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .stat      (q_stat)
    );

    nrmc_back #(
        .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_stat              (q_stat),
        .q_pop               (q_pop),
        .rec_fix_ok          (bk_ok),
        .rec_time            (bk_time),
        .rec_lat_whole       (bk_latw),
        .rec_lat_frac        (bk_latf),
        .rec_lon_whole       (bk_lonw),
        .rec_lon_frac        (bk_lonf),
        .rec_hem             (bk_hem),
        .utc_offset          (utc_offset_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_local_time_hhmmss (m_local_time_hhmmss),
        .m_fix_valid         (m_fix_valid),
        .m_latitude_e7       (m_latitude_e7),
        .m_lat_south         (m_lat_south),
        .m_longitude_e7      (m_longitude_e7),
        .m_lon_west          (m_lon_west)
    );

endmodule

// ===== tb/tb_nmea_rmc_sentence_parser.sv =====
module tb_nmea_rmc_sentence_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int FRAC_DIGITS = MINUTE_FRACTION_DIGITS_DEF;
    localparam int MAX_BYTES   = MAX_SENTENCE_BYTES_DEF;
    localparam longint unsigned MIN_SCALE  = 10 ** FRAC_DIGITS;
    localparam longint unsigned E7_SCALE   = 10 ** (7 - FRAC_DIGITS);
    localparam longint unsigned LAT_E7_CAP = 900000000;
    localparam longint unsigned LON_E7_CAP = 1800000000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [HHMMSS_W-1:0] hhmmss;
        logic                fix;
        logic [LAT_E7_W-1:0] lat;
        logic                south;
        logic [LON_E7_W-1:0] lon;
        logic                west;
    } rmc_fix_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [7:0]          s_rx_byte   = 8'h00;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [HHMMSS_W-1:0] m_local_time_hhmmss;
    logic                m_fix_valid;
    logic [LAT_E7_W-1:0] m_latitude_e7;
    logic                m_lat_south;
    logic [LON_E7_W-1:0] m_longitude_e7;
    logic                m_lon_west;
    logic                cfg_wr_en   = 1'b0;
    logic [OFFSET_W-1:0] cfg_wr_data = '0;

    logic [7:0]  byte_q [$];
    rmc_fix_t    fix_q [$];
    rmc_fix_t    new_fix;
    rmc_fix_t    want_fix;
    int unsigned bytes_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    bit          calm         = 1'b0;

    // Sentence tracking state of the predictor
    logic [7:0]  hdr_chars [6] = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C};
    int unsigned hdr_idx = 0, fld = 0, nbytes = 0, frac_cnt = 0;
    int unsigned time_acc = 0, lat_w = 0, lat_f = 0, lon_w = 0, lon_f = 0;
    bit          past_point = 1'b0, stat_a = 1'b0, hem_s = 1'b0, hem_w = 1'b0;
    logic [OFFSET_W-1:0] utc_hours = UTC_OFFSET_RESET;

    nmea_rmc_sentence_parser #(
        .MINUTE_FRACTION_DIGITS(FRAC_DIGITS),
        .MAX_SENTENCE_BYTES    (MAX_BYTES)
    ) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_rx_byte          (s_rx_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_local_time_hhmmss(m_local_time_hhmmss),
        .m_fix_valid        (m_fix_valid),
        .m_latitude_e7      (m_latitude_e7),
        .m_lat_south        (m_lat_south),
        .m_longitude_e7     (m_longitude_e7),
        .m_lon_west         (m_lon_west),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic longint unsigned to_e7(input longint unsigned whole, frac, cap);
        longint unsigned v;
        v = (whole / 100) * 64'd10000000 + ((whole % 100) * MIN_SCALE + frac) * E7_SCALE / 60;
        return (v > cap) ? cap : v;
    endfunction

    function automatic rmc_fix_t sentence_fix(input bit valid);
        rmc_fix_t    r;
        int unsigned hh, rest;
        hh   = time_acc / 10000;
        rest = time_acc % 10000;
        r = '0;
        r.hhmmss = HHMMSS_W'(((hh + utc_hours) % 24) * 10000 + rest);
        r.fix    = valid;
        if (valid) begin
            r.lat   = LAT_E7_W'(to_e7(lat_w, lat_f, LAT_E7_CAP));
            r.south = hem_s;
            r.lon   = LON_E7_W'(to_e7(lon_w, lon_f, LON_E7_CAP));
            r.west  = hem_w;
        end
        hdr_idx = 0;
        return r;
    endfunction

    // Advance the sentence tracker by one byte; return 1 when a fix is reported
    function automatic bit rmc_step(input logic [7:0] b, output rmc_fix_t r);
        bit          is_digit;
        int unsigned d, v;
        is_digit = (b >= CH_ZERO && b <= CH_NINE);
        d = is_digit ? int'(b - CH_ZERO) : 0;
        r = '0;
        if (b == CH_DOLLAR) begin
            fld = 0; frac_cnt = 0; past_point = 0; time_acc = 0;
            lat_w = 0; lat_f = 0; lon_w = 0; lon_f = 0;
            hem_s = 0; hem_w = 0; stat_a = 0;
            hdr_idx = 1;
            nbytes = 1;
            return 0;
        end
        if (hdr_idx == 0) return 0;
        if (nbytes >= MAX_BYTES) begin
            hdr_idx = 0;
            return 0;
        end
        nbytes++;
        if (hdr_idx < 6) begin
            if (b == hdr_chars[hdr_idx]) hdr_idx++;
            else hdr_idx = 0;
            return 0;
        end
        if (b == CH_STAR || b == CH_CR || b == CH_LF) begin
            hdr_idx = 0;
            return 0;
        end
        if (b == CH_COMMA) begin
            if (fld == 2 && !stat_a) begin
                r = sentence_fix(1'b0);
                return 1;
            end
            if (fld == 6) begin
                r = sentence_fix(1'b1);
                return 1;
            end
            // missing minute digits count as trailing zeros
            if (fld == 3) lat_f = lat_f * (10 ** (FRAC_DIGITS - frac_cnt));
            if (fld == 5) lon_f = lon_f * (10 ** (FRAC_DIGITS - frac_cnt));
            fld++;
            past_point = 0;
            frac_cnt = 0;
            return 0;
        end
        case (fld)
            1: begin
                if (b == CH_POINT) begin
                    past_point = 1;
                end else if (is_digit && !past_point) begin
                    v = time_acc * 10 + d;
                    time_acc = (v > TIME_CAP) ? TIME_CAP : v;
                end
            end
            2: begin
                if (!past_point) begin
                    stat_a = (b == CH_A);
                    past_point = 1;
                end
            end
            3: begin
                if (b == CH_POINT) begin
                    past_point = 1;
                end else if (is_digit && !past_point) begin
                    v = lat_w * 10 + d;
                    lat_w = (v > LAT_WHOLE_CAP) ? LAT_WHOLE_CAP : v;
                end else if (is_digit && frac_cnt < FRAC_DIGITS) begin
                    lat_f = lat_f * 10 + d;
                    frac_cnt++;
                end
            end
            4: hem_s = (b == CH_S);
            5: begin
                if (b == CH_POINT) begin
                    past_point = 1;
                end else if (is_digit && !past_point) begin
                    v = lon_w * 10 + d;
                    lon_w = (v > LON_WHOLE_CAP) ? LON_WHOLE_CAP : v;
                end else if (is_digit && frac_cnt < FRAC_DIGITS) begin
                    lon_f = lon_f * 10 + d;
                    frac_cnt++;
                end
            end
            6: hem_w = (b == CH_W);
            default: ;
        endcase
        return 0;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: hold each beat until accepted, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                bytes_sent++;
                if (rmc_step(s_rx_byte, new_fix)) fix_q.push_back(new_fix);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= byte_q.pop_front();
                send_gap  = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Monitor: compare each result beat with the oldest predicted fix
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (fix_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hhmmss %0d fix %0d",
                             $time, m_local_time_hhmmss, m_fix_valid);
                    fail_count++;
                end else begin
                    want_fix = fix_q.pop_front();
                    check_field("local_time_hhmmss", want_fix.hhmmss, m_local_time_hhmmss);
                    check_field("fix_valid", want_fix.fix, m_fix_valid);
                    check_field("latitude_e7", want_fix.lat, m_latitude_e7);
                    check_field("lat_south", want_fix.south, m_lat_south);
                    check_field("longitude_e7", want_fix.lon, m_longitude_e7);
                    check_field("lon_west", want_fix.west, m_lon_west);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready  <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
    endtask

    task automatic push_dec(input int unsigned v, input int w);
        for (int i = w - 1; i >= 0; i--) byte_q.push_back(CH_ZERO + 8'((v / (10 ** i)) % 10));
    endtask

    task automatic push_digits(input int unsigned n);
        repeat (n) byte_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Printable filler that never starts, ends or splits a sentence
    task automatic push_junk();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
        byte_q.push_back(c);
    endtask

    task automatic push_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            push_dec($urandom_range(0, 23), 2);
            push_dec($urandom_range(0, 59), 2);
            push_dec($urandom_range(0, 59), 2);
        end else if (r < 85) begin
            push_dec($urandom_range(0, 999999), 6);
        end else if (r < 93) begin
            push_digits($urandom_range(7, 9));
        end else begin
            push_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 1)) begin
            byte_q.push_back(CH_POINT);
            push_digits($urandom_range(0, 3));
        end
    endtask

    task automatic push_status();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            byte_q.push_back(CH_A);
        end else if (r < 85) begin
            push_text("V");
        end else if (r < 95) begin
            if (r >= 90) begin
                byte_q.push_back(CH_A);
                push_junk();
            end
        end else begin
            push_junk();
        end
    endtask

    task automatic push_coord(input int deg_w);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(0, 6)) push_junk();
            return;
        end
        push_dec($urandom_range(0, (deg_w == 2) ? 99 : 199), deg_w);
        push_dec($urandom_range(0, 59), 2);
        if ($urandom_range(0, 9) == 0) push_digits($urandom_range(1, 3));
        if ($urandom_range(0, 9) != 0) begin
            byte_q.push_back(CH_POINT);
            push_digits($urandom_range(0, 7));
        end
        // stray character and a second point
        if ($urandom_range(0, 9) == 0) begin
            push_junk();
            byte_q.push_back(CH_POINT);
            push_digits($urandom_range(1, 3));
        end
    endtask

    task automatic push_hem(input logic [7:0] plain, input logic [7:0] alt);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            byte_q.push_back(plain);
        end else if (r < 90) begin
            byte_q.push_back(alt);
        end else if (r < 97) begin
            if (r >= 94) begin
                byte_q.push_back($urandom_range(0, 1) ? plain : alt);
                byte_q.push_back($urandom_range(0, 1) ? plain : alt);
            end
        end else begin
            push_junk();
        end
    endtask

    task automatic queue_random_sentence();
        int unsigned kind, cut, r;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 16)) byte_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        cut = (kind < 18) ? $urandom_range(1, 7) : 99;
        if (kind >= 18 && kind < 23) begin
            push_text("$GP");
            push_junk();
            push_text("MC");
        end else if (kind >= 23 && kind < 26) begin
            // long filler in the sentence id field, towards or past the length limit
            push_text("$GPRMC");
            repeat ($urandom_range(60, 75)) push_junk();
        end else begin
            push_text("$GPRMC");
        end
        for (int f = 1; f <= 7; f++) begin
            if (f == cut) begin
                r = $urandom_range(0, 3);
                byte_q.push_back((r == 0) ? CH_STAR : (r == 1) ? CH_CR :
                                 (r == 2) ? CH_LF : CH_DOLLAR);
                return;
            end
            byte_q.push_back(CH_COMMA);
            case (f)
                1: push_time();
                2: push_status();
                3: push_coord(2);
                4: push_hem("N", CH_S);
                5: push_coord(3);
                6: push_hem("E", CH_W);
                default: ;
            endcase
        end
        repeat ($urandom_range(0, 8)) push_junk();
        byte_q.push_back(CH_STAR);
        push_junk();
        push_junk();
        byte_q.push_back(CH_CR);
        byte_q.push_back(CH_LF);
    endtask

    // Wait until all bytes are taken and every predicted fix has come out
    task automatic wait_idle();
        do @(negedge aclk);
        while (byte_q.size() != 0 || s_valid || fix_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int unsigned phase;
        logic [OFFSET_W-1:0] new_hours;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_text("$GPRMC,123519.00,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
        push_text("$GPRMC,235959.999,A,9000.00000,S,18000.00000,W,*00\r\n");
        push_text("$GPRMC,9999999,A,99999.9999999,N,999999.9999999,E,\r\n");
        push_text("$GPRMC,000000,A,0000.00000,N,00000.00000,E,\r\n");
        push_text("$GPRMC,081836,V,3751.65,S,14507.36,E,*7E\r\n");
        push_text("$GPRMC,,,,,,,\r\n");
        push_text("$GPRMC,1200,VA,1,N,2,E,\r\n");
        push_text("$GPRMC,1a2b3c.4.5,AV,12x34.5.67,NS,123.45.6,WE,\r\n");
        push_text("$GPRMC,200000,A,4807.038,SN,01131.000,EW,\r\n");
        push_text("$GPRMC,120000,A,4807*$GPRMC,120000,A,48\r$GPRMC,1\n");
        push_text("$GPGGA,123519,A,4807.038,N,01131.000,E,\r\n");
        push_text("$GPRM$GPRMC,010203,A,0100.0,N,00100.0,E,\r\n");
        push_text("$GPRMC,,A,,,,,\r\n");
        // the closing comma lands exactly on the length limit, then one past it
        for (int pad = 64; pad <= 65; pad++) begin
            push_text("$GPRMC,");
            repeat (pad) push_text("x");
            push_text("123456,V,\r\n");
        end
        wait_idle();

        phase = 0;
        while (bytes_sent < 1150) begin
            case (phase)
                0: new_hours = '0;
                1: new_hours = 5'd23;
                2: new_hours = 5'd15;
                3: new_hours = 5'd16;
                default: new_hours = OFFSET_W'($urandom_range(0, 23));
            endcase
            @(posedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= new_hours;
            @(posedge aclk);
            cfg_wr_en <= 1'b0;
            utc_hours = new_hours;
            @(negedge aclk);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 10)) queue_random_sentence();
            wait_idle();
            phase++;
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
